>>> src/keyframe_timeline_sampler_macros.svh
// Assertion macros for the keyframe timeline sampler checker.
// Depends on nothing; included by the checker file only.
`ifndef KEYFRAME_TIMELINE_SAMPLER_MACROS_SVH
`define KEYFRAME_TIMELINE_SAMPLER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define KTS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define KTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/kts_pkg.sv
// Shared codes and stage payload types of the keyframe timeline sampler.
// Depends on nothing; imported by kts_front and the top module.
package kts_pkg;

  // Play mode codes; the unused code behaves as clamp.
  localparam logic [1:0] MODE_CLAMP    = 2'd0;
  localparam logic [1:0] MODE_WRAP     = 2'd1;
  localparam logic [1:0] MODE_MIRROR   = 2'd2;
  localparam logic [1:0] MODE_RESERVED = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_FRAME_COUNT = 1'b0;
  localparam logic CFG_FRAME_RATE  = 1'b1;

  localparam int unsigned FcW  = 13;
  localparam int unsigned FrW  = 24;
  localparam int unsigned MhW  = 24;
  localparam int unsigned IdxW = 12;

  // Front end result, carried alongside the span division.
  typedef struct packed {
    logic [MhW-1:0] mh;         // integer part of |position|
    logic           t_neg;
    logic           t_nonpos;
    logic           pos_neg;
    logic           low_nz;     // fraction bits of position nonzero
    logic [1:0]     mode;
    logic [8:0]     levels;
    logic [16:0]    vsel;       // unquantized blend, may reach 1.0
    logic [9:0]     qlev;       // floor(vsel * levels / 65536)
    logic [FcW-1:0] span;
    logic           short_clip;
  } trk_t;

  // Frame result, carried alongside the blend quantizer division.
  typedef struct packed {
    logic [IdxW-1:0] frame;
    logic [IdxW-1:0] next_frame;
    logic            zero_bl;
    logic [8:0]      levels;
    logic [16:0]     vsel;
    logic [9:0]      qlev;
  } res_t;

endpackage

>>> src/kts_div.sv
// Pipelined restoring divider, eight quotient bits per register stage.
// Depends on nothing; each stage has its own valid bit and ready term.
module kts_div #(
  parameter int unsigned DW = 24,
  parameter int unsigned VW = 13,
  parameter int unsigned PW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  input  logic [PW-1:0] payload_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [DW-1:0] quotient_o,
  output logic [VW-1:0] remainder_o,
  output logic [PW-1:0] payload_o
);

  localparam int unsigned Steps = 8;
  localparam int unsigned NumStages = (DW + Steps - 1) / Steps;

  logic [NumStages-1:0]         valid_q;
  logic [NumStages-1:0][DW-1:0] acc_q, acc_d;
  logic [NumStages-1:0][VW-1:0] rem_q, rem_d;
  logic [NumStages-1:0][VW-1:0] dvs_q, dvs_d;
  logic [NumStages-1:0][PW-1:0] pay_q, pay_d;
  logic [NumStages-1:0]         vin;
  logic [NumStages:0]           rdy;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  function automatic logic [DW+VW-1:0] div_step(input logic [DW+VW-1:0] ar,
                                                input logic [VW-1:0] d);
    logic [VW:0]   tr;
    logic [VW-1:0] rn;
    logic          qb;
    tr = {ar[VW-1:0], ar[DW+VW-1]};
    if (tr >= {1'b0, d}) begin
      rn = VW'(tr - {1'b0, d});
      qb = 1'b1;
    end else begin
      rn = tr[VW-1:0];
      qb = 1'b0;
    end
    return {ar[DW+VW-2:VW], qb, rn};
  endfunction

  // Stage advance and the steps each stage performs.
  always_comb begin
    logic [DW+VW-1:0] ar;
    logic [VW-1:0]    d;
    rdy[NumStages] = out_ready_i;
    for (int s = NumStages - 1; s >= 0; s--) begin
      rdy[s] = !valid_q[s] || rdy[s+1];
    end
    vin[0]   = in_valid_i;
    acc_d[0] = dividend_i;
    rem_d[0] = '0;
    dvs_d[0] = divisor_i;
    pay_d[0] = payload_i;
    for (int s = 1; s < NumStages; s++) begin
      vin[s]   = valid_q[s-1];
      acc_d[s] = acc_q[s-1];
      rem_d[s] = rem_q[s-1];
      dvs_d[s] = dvs_q[s-1];
      pay_d[s] = pay_q[s-1];
    end
    for (int s = 0; s < NumStages; s++) begin
      ar = {acc_d[s], rem_d[s]};
      d  = dvs_d[s];
      for (int t = 0; t < Steps; t++) begin
        if (s * Steps + t < DW) begin
          ar = div_step(ar, d);
        end
      end
      acc_d[s] = ar[DW+VW-1:VW];
      rem_d[s] = ar[VW-1:0];
    end
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int s = 0; s < NumStages; s++) begin
        if (rdy[s]) begin
          valid_q[s] <= vin[s];
        end
      end
    end
  end

  // Stage data.
  always_ff @(posedge clk_i) begin
    for (int s = 0; s < NumStages; s++) begin
      if (rdy[s]) begin
        acc_q[s] <= acc_d[s];
        rem_q[s] <= rem_d[s];
        dvs_q[s] <= dvs_d[s];
        pay_q[s] <= pay_d[s];
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = valid_q[NumStages-1];
  assign quotient_o  = acc_q[NumStages-1];
  assign remainder_o = rem_q[NumStages-1];
  assign payload_o   = pay_q[NumStages-1];

endmodule

>>> src/kts_front.sv
// Front end: time by rate multiply, then magnitude, blend product and span.
// Depends on kts_pkg; two register stages with their own valid bits.
module kts_front #(
  parameter int unsigned MAX_FRAMES = 4096
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [31:0]        timeline_i,
  input  logic [1:0]                play_mode_i,
  input  logic [8:0]                blend_levels_i,
  input  logic [kts_pkg::FcW-1:0]   frame_count_i,
  input  logic [kts_pkg::FrW-1:0]   frame_rate_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output kts_pkg::trk_t             out_trk_o
);

  import kts_pkg::*;

  logic               v1_q, v2_q, rdy1, rdy2;
  logic signed [55:0] pos_q;
  logic               t_neg_q, t_nonpos_q;
  logic [1:0]         mode_q;
  logic [8:0]         levels_q;
  logic signed [56:0] prod;
  trk_t               trk_d, trk_q;
  logic [55:0]        mag;
  logic [15:0]        v;
  logic [25:0]        qmul;
  logic [FcW-1:0]     fc_lim;

  assign rdy2       = !v2_q || out_ready_i;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  // Stage one: signed Q24.32 position.
  assign prod = $signed(timeline_i) * $signed({1'b0, frame_rate_i});

  // Stage two: split the position and prepare both divisions.
  always_comb begin
    mag    = pos_q[55] ? 56'(-pos_q) : 56'(pos_q);
    v      = pos_q[31:16];
    fc_lim = (32'(frame_count_i) > MAX_FRAMES) ? FcW'(MAX_FRAMES) : frame_count_i;
    trk_d.mh         = mag[55:32];
    trk_d.t_neg      = t_neg_q;
    trk_d.t_nonpos   = t_nonpos_q;
    trk_d.pos_neg    = pos_q[55];
    trk_d.low_nz     = (pos_q[31:0] != 32'd0);
    trk_d.mode       = mode_q;
    trk_d.levels     = levels_q;
    trk_d.vsel       = ((mode_q == MODE_WRAP || mode_q == MODE_MIRROR) && t_neg_q) ?
                       17'(17'h10000 - {1'b0, v}) : {1'b0, v};
    qmul             = trk_d.vsel * levels_q;
    trk_d.qlev       = qmul[25:16];
    trk_d.short_clip = (fc_lim <= FcW'(1));
    trk_d.span       = trk_d.short_clip ? '0 : FcW'(fc_lim - FcW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      pos_q      <= prod[55:0];
      t_neg_q    <= timeline_i[31];
      t_nonpos_q <= timeline_i[31] || (timeline_i == 32'sd0);
      mode_q     <= play_mode_i;
      levels_q   <= blend_levels_i;
    end
    if (rdy2) begin
      trk_q <= trk_d;
    end
  end

  assign out_valid_o = v2_q;
  assign out_trk_o   = trk_q;

endmodule

>>> src/keyframe_timeline_sampler.sv
// Pipeline: 2 front stages, 3 span divider stages, 1 frame stage and 4 blend
// divider stages. Throughput: one transaction per cycle while out_ready_i
// does not stall the output; every stage has its own valid bit.
// Reset: asynchronous, active low; clears all valid bits, frame_count to 1
// and frame_rate to 3932160. Payload registers are not reset.
module keyframe_timeline_sampler #(
  parameter int unsigned MAX_FRAMES = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [23:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] timeline_i,
  input  logic [1:0]         play_mode_i,
  input  logic [8:0]         blend_levels_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [11:0]        frame_o,
  output logic [11:0]        next_frame_o,
  output logic [15:0]        blend_o
);

  import kts_pkg::*;

  localparam int unsigned TrkW = $bits(trk_t);
  localparam int unsigned ResW = $bits(res_t);

  logic [FcW-1:0]  frame_count_q;
  logic [FrW-1:0]  frame_rate_q;
  logic            fe_valid, fe_ready;
  trk_t            fe_trk, da_trk;
  logic [TrkW-1:0] da_pay;
  logic            da_valid, da_ready;
  logic [MhW-1:0]  da_quo;
  logic [FcW-1:0]  da_rem;
  logic            s3_v_q, s3_rdy;
  res_t            s3_d, s3_q, db_res;
  logic [ResW-1:0] db_pay;
  logic            db_ready;
  logic [25:0]     db_quo;
  logic [8:0]      db_rem;
  logic [FcW-1:0]  k, fr, nx;
  logic [25:0]     bl_raw;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= FcW'(1);
      frame_rate_q  <= FrW'(3932160);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FRAME_COUNT: frame_count_q <= cfg_data_i[FcW-1:0];
        CFG_FRAME_RATE:  frame_rate_q  <= cfg_data_i[FrW-1:0];
        default:         frame_rate_q  <= frame_rate_q;
      endcase
    end
  end

  kts_front #(.MAX_FRAMES(MAX_FRAMES)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .timeline_i     (timeline_i),
    .play_mode_i    (play_mode_i),
    .blend_levels_i (blend_levels_i),
    .frame_count_i  (frame_count_q),
    .frame_rate_i   (frame_rate_q),
    .out_valid_o    (fe_valid),
    .out_ready_i    (fe_ready),
    .out_trk_o      (fe_trk)
  );

  // Whole periods and position within the period.
  kts_div #(.DW(MhW), .VW(FcW), .PW(TrkW)) u_span_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fe_valid),
    .in_ready_o  (fe_ready),
    .dividend_i  (fe_trk.mh),
    .divisor_i   (fe_trk.span),
    .payload_i   (fe_trk),
    .out_valid_o (da_valid),
    .out_ready_i (da_ready),
    .quotient_o  (da_quo),
    .remainder_o (da_rem),
    .payload_o   (da_pay)
  );

  assign da_trk = da_pay;

  // Frame stage: clamp, wrap and mirror selection.
  always_comb begin
    if (!da_trk.pos_neg) begin
      k = da_rem;
    end else if (da_rem == '0 && !da_trk.low_nz) begin
      k = '0;
    end else begin
      k = FcW'(da_trk.span - da_rem - FcW'(da_trk.low_nz));
    end
    s3_d.zero_bl = 1'b0;
    if (da_trk.short_clip) begin
      fr = '0;
      nx = '0;
      s3_d.zero_bl = 1'b1;
    end else if (da_trk.mode == MODE_WRAP || da_trk.mode == MODE_MIRROR) begin
      if (da_trk.t_neg) begin
        fr = FcW'(k + FcW'(1));
        nx = k;
      end else begin
        fr = k;
        nx = FcW'(k + FcW'(1));
      end
      if (da_trk.mode == MODE_MIRROR && da_quo[0]) begin
        fr = FcW'(da_trk.span - fr);
        nx = FcW'(da_trk.span - nx);
      end
    end else if (da_trk.t_nonpos) begin
      fr = '0;
      nx = '0;
      s3_d.zero_bl = 1'b1;
    end else if (da_quo != '0) begin
      fr = da_trk.span;
      nx = da_trk.span;
      s3_d.zero_bl = 1'b1;
    end else begin
      fr = da_trk.mh[FcW-1:0];
      nx = FcW'(da_trk.mh[FcW-1:0] + FcW'(1));
    end
    s3_d.frame      = fr[IdxW-1:0];
    s3_d.next_frame = nx[IdxW-1:0];
    s3_d.levels     = da_trk.levels;
    s3_d.vsel       = da_trk.vsel;
    s3_d.qlev       = da_trk.qlev;
  end

  assign s3_rdy   = !s3_v_q || db_ready;
  assign da_ready = s3_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (s3_rdy) begin
      s3_v_q <= da_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_rdy) begin
      s3_q <= s3_d;
    end
  end

  // Blend quantizer: floor(q * 65536 / levels).
  kts_div #(.DW(26), .VW(9), .PW(ResW)) u_blend_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s3_v_q),
    .in_ready_o  (db_ready),
    .dividend_i  ({s3_q.qlev, 16'h0000}),
    .divisor_i   (s3_q.levels),
    .payload_i   (s3_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .quotient_o  (db_quo),
    .remainder_o (db_rem),
    .payload_o   (db_pay)
  );

  assign db_res = db_pay;

  // Output selection and saturation of a full weight.
  always_comb begin
    bl_raw = (db_res.levels == 9'd0) ? {9'd0, db_res.vsel} : db_quo;
    if (db_res.zero_bl) begin
      blend_o = '0;
    end else if (bl_raw > 26'd65535 || db_rem == 9'h1FF) begin
      blend_o = (bl_raw > 26'd65535) ? 16'hFFFF : bl_raw[15:0];
    end else begin
      blend_o = bl_raw[15:0];
    end
  end

  assign frame_o      = db_res.frame;
  assign next_frame_o = db_res.next_frame;

endmodule

>>> src/kts_checker.sv
// Port-level checker for the keyframe timeline sampler, bound to the top.
// Depends on keyframe_timeline_sampler_macros.svh.
`include "keyframe_timeline_sampler_macros.svh"

module kts_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [11:0] frame_o,
  input logic [11:0] next_frame_o,
  input logic [15:0] blend_o
);

  logic same_idx;
  logic adjacent_idx;

  // Relations between the two frame indices of a result.
  assign same_idx     = (frame_o == next_frame_o);
  assign adjacent_idx = (12'(frame_o - next_frame_o) == 12'd1) ||
                        (12'(next_frame_o - frame_o) == 12'd1);

  // A stalled input transaction stays offered.
  `KTS_ASSERT_NEXT(a_in_hold, in_valid_i && !in_ready_o, in_valid_i, "input dropped")

  // A stalled result transaction stays offered.
  `KTS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped")

  // Input is held off only when the pipeline is full up to its output.
  `KTS_ASSERT_IMPL(a_full_only, !in_ready_o, out_valid_o && !out_ready_i, "stalled with room")

  // Equal frame indices carry no weight.
  `KTS_ASSERT_IMPL(a_same_zero, out_valid_o && same_idx, blend_o == 16'd0, "weight on one frame")

  // Distinct frame indices are neighbors.
  `KTS_ASSERT_IMPL(a_adjacent, out_valid_o && !same_idx, adjacent_idx, "frames not adjacent")

endmodule

bind keyframe_timeline_sampler kts_checker u_kts_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .frame_o      (frame_o),
  .next_frame_o (next_frame_o),
  .blend_o      (blend_o)
);
